// ----- hw/rtl/ssme_pkg.sv -----
// Shared types and constants for the sorted set merge engine.
// Used by ssme_ctrl, ssme_dp, sorted_set_merge_engine_unit and the testbench.
`default_nettype none

package ssme_pkg;

   localparam int ELEM_W        = 32;
   localparam int MODE_W        = 3;
   localparam int STATUS_W      = 3;
   localparam int SET_DEPTH_DEF = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_A  = 3'd0,
      MODE_LOAD_B  = 3'd1,
      MODE_UNION   = 3'd2,
      MODE_INTER   = 3'd3,
      MODE_DIFF    = 3'd4,
      MODE_SYMDIFF = 3'd5,
      MODE_CLEAR   = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ELEM    = 3'd0,
      STAT_LOADED  = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_ORDER   = 3'd3,
      STAT_EMPTY   = 3'd4,
      STAT_CLEARED = 3'd5
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_MERGE = 1'b1
   } state_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic clear;
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic merge_done;
   } stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_set_merge_engine_unit.sv -----
// Top level of the sorted set merge engine.
// Depends on ssme_pkg, ssme_ctrl, ssme_dp and ssme_ram.
//
// Two sets of signed 32-bit elements are loaded in strictly ascending order
// into stores A and B, each SET_DEPTH entries deep. Loads, clear and the
// unused mode never enter the merge state, so such requests are accepted
// one per cycle while the result register drains. A merge request (union,
// intersection, A minus B, symmetric difference) holds off new requests
// while the two-pointer walk runs: one walk step per cycle while the result
// side does not stall, at most count_a + count_b steps, then a closing
// finish step. The step rate is set by the single registered read
// port of each store. Elements come out in ascending order, the final one
// with last set; a merge with nothing to emit gives one empty status.
`default_nettype none

module sorted_set_merge_engine_unit #(
   parameter int SET_DEPTH = ssme_pkg::SET_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [ssme_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [ssme_pkg::ELEM_W-1:0]   req_element,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [ssme_pkg::ELEM_W-1:0]   rsp_result_value,
   output      logic [ssme_pkg::STATUS_W-1:0] rsp_status,
   output      logic                          rsp_last
);

   import ssme_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ssme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssme_dp #(.SET_DEPTH(SET_DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_mode),
      .req_element      (req_element),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/ssme_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ssme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ssme_ctrl.sv -----
// Controller state machine for the sorted set merge engine.
// Depends on ssme_pkg; drives commands into ssme_dp.
`default_nettype none

module ssme_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [ssme_pkg::MODE_W-1:0] req_mode,
   input  wire ssme_pkg::stat_type          stat,
   output      ssme_pkg::cmd_type           cmd
);

   import ssme_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && stat.slot_free;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_UNION, MODE_INTER, MODE_DIFF, MODE_SYMDIFF: begin
                     state_in = S_MERGE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MERGE: begin
            if (stat.slot_free && stat.merge_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_LOAD_A: begin
                     cmd.load_a = 1'b1;
                  end
                  MODE_LOAD_B: begin
                     cmd.load_b = 1'b1;
                  end
                  MODE_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  MODE_UNION, MODE_INTER, MODE_DIFF, MODE_SYMDIFF: begin
                     cmd.start = 1'b1;
                  end
                  default: begin
                     cmd = '0;
                  end
               endcase
            end
         end
         S_MERGE: begin
            if (stat.slot_free) begin
               cmd.finish = stat.merge_done;
               cmd.step   = !stat.merge_done;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ssme_dp.sv -----
// Datapath of the sorted set merge engine: both stores, counts, merge
// pointers, pending element and the result register.
// Depends on ssme_pkg and ssme_ram.
`default_nettype none

module ssme_dp #(
   parameter int SET_DEPTH = ssme_pkg::SET_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ssme_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [ssme_pkg::ELEM_W-1:0]   req_element,
   input  wire ssme_pkg::cmd_type             cmd,
   output      ssme_pkg::stat_type            stat,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [ssme_pkg::ELEM_W-1:0]   rsp_result_value,
   output      logic [ssme_pkg::STATUS_W-1:0] rsp_status,
   output      logic                          rsp_last
);

   import ssme_pkg::*;

   localparam int CNT_W  = $clog2(SET_DEPTH + 1);
   localparam int ADDR_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

   logic [CNT_W-1:0]  count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [ELEM_W-1:0] last_a_ff, last_a_in, last_b_ff, last_b_in;
   logic [ELEM_W-1:0] pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   mode_type          kind_ff, kind_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_value_ff;
   status_type        rsp_status_ff;
   logic              rsp_last_ff;

   logic              push;
   logic [ELEM_W-1:0] push_value;
   status_type        push_status;
   logic              push_last;

   logic              wr_a, wr_b;
   logic [ELEM_W-1:0] data_a, data_b;
   logic              has_a, has_b, a_lt_b, b_lt_a;
   logic              take_a, take_b, take_both, emit;
   logic              keep_a_only, keep_b_only, keep_both;
   logic [ELEM_W-1:0] step_value;
   logic              full_a, full_b, order_ok_a, order_ok_b;

   ssme_ram #(.WIDTH(ELEM_W), .DEPTH(SET_DEPTH), .ADDR_W(ADDR_W)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[ADDR_W-1:0]),
      .wr_data (req_element),
      .rd_addr (i_in[ADDR_W-1:0]),
      .rd_data (data_a)
   );

   ssme_ram #(.WIDTH(ELEM_W), .DEPTH(SET_DEPTH), .ADDR_W(ADDR_W)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[ADDR_W-1:0]),
      .wr_data (req_element),
      .rd_addr (j_in[ADDR_W-1:0]),
      .rd_data (data_b)
   );

   // The read address follows the next pointer, so the read data always
   // belongs to the current pointer.
   assign has_a     = (i_ff < count_a_ff);
   assign has_b     = (j_ff < count_b_ff);
   assign a_lt_b    = ($signed(data_a) < $signed(data_b));
   assign b_lt_a    = ($signed(data_b) < $signed(data_a));
   assign take_a    = !has_b || (has_a && a_lt_b);
   assign take_b    = !take_a && (!has_a || b_lt_a);
   assign take_both = !take_a && !take_b;
   assign step_value = take_b ? data_b : data_a;

   assign keep_a_only = (kind_ff == MODE_UNION) || (kind_ff == MODE_DIFF) ||
                        (kind_ff == MODE_SYMDIFF);
   assign keep_b_only = (kind_ff == MODE_UNION) || (kind_ff == MODE_SYMDIFF);
   assign keep_both   = (kind_ff == MODE_UNION) || (kind_ff == MODE_INTER);
   assign emit = (take_a && keep_a_only) || (take_b && keep_b_only) ||
                 (take_both && keep_both);

   assign full_a     = (count_a_ff == CNT_W'(SET_DEPTH));
   assign full_b     = (count_b_ff == CNT_W'(SET_DEPTH));
   assign order_ok_a = (count_a_ff == '0) || ($signed(last_a_ff) < $signed(req_element));
   assign order_ok_b = (count_b_ff == '0) || ($signed(last_b_ff) < $signed(req_element));

   assign stat.slot_free  = !rsp_valid_ff || rsp_ready;
   assign stat.merge_done = !has_a && !has_b;

   always_comb begin
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      last_a_in     = last_a_ff;
      last_b_in     = last_b_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      kind_in       = kind_ff;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      push          = 1'b0;
      push_value    = '0;
      push_status   = STAT_ELEM;
      push_last     = 1'b0;

      if (cmd.load_a) begin
         push      = 1'b1;
         push_last = 1'b1;
         if (full_a) begin
            push_status = STAT_FULL;
         end else if (!order_ok_a) begin
            push_status = STAT_ORDER;
         end else begin
            push_status = STAT_LOADED;
            wr_a        = 1'b1;
            count_a_in  = count_a_ff + CNT_W'(1);
            last_a_in   = req_element;
         end
      end

      if (cmd.load_b) begin
         push      = 1'b1;
         push_last = 1'b1;
         if (full_b) begin
            push_status = STAT_FULL;
         end else if (!order_ok_b) begin
            push_status = STAT_ORDER;
         end else begin
            push_status = STAT_LOADED;
            wr_b        = 1'b1;
            count_b_in  = count_b_ff + CNT_W'(1);
            last_b_in   = req_element;
         end
      end

      if (cmd.clear) begin
         count_a_in  = '0;
         count_b_in  = '0;
         push        = 1'b1;
         push_status = STAT_CLEARED;
         push_last   = 1'b1;
      end

      if (cmd.start) begin
         kind_in       = mode_type'(req_mode);
         pend_valid_in = 1'b0;
      end

      // A found element waits in the pending register until the next one
      // is found or the walk ends, so that the final one can carry last.
      if (cmd.step) begin
         if (take_a || take_both) begin
            i_in = i_ff + CNT_W'(1);
         end
         if (take_b || take_both) begin
            j_in = j_ff + CNT_W'(1);
         end
         if (emit) begin
            pend_in       = step_value;
            pend_valid_in = 1'b1;
            if (pend_valid_ff) begin
               push       = 1'b1;
               push_value = pend_ff;
            end
         end
      end

      if (cmd.finish) begin
         i_in          = '0;
         j_in          = '0;
         pend_valid_in = 1'b0;
         push          = 1'b1;
         push_last     = 1'b1;
         if (pend_valid_ff) begin
            push_value = pend_ff;
         end else begin
            push_status = STAT_EMPTY;
         end
      end
   end

   assign rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         kind_ff       <= MODE_UNION;
      end else begin
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         kind_ff       <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      last_a_ff <= last_a_in;
      last_b_ff <= last_b_in;
      pend_ff   <= pend_in;
      if (push) begin
         rsp_value_ff  <= push_value;
         rsp_status_ff <= push_status;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

// ----- tb/sorted_set_merge_engine_unit_test.sv -----
// Self-checking testbench for sorted_set_merge_engine_unit: loads, merges, clear and ignored
// requests are driven with random idling on both channels and checked by a scoreboard.
// Depends on ssme_pkg and the sorted_set_merge_engine_unit RTL.
module sorted_set_merge_engine_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ssme_pkg::*;

   localparam int DEPTH = SET_DEPTH_DEF;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;
   localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
   localparam longint ELEM_MIN_L = -64'sd2147483648;
   localparam longint ELEM_MAX_L = 64'sd2147483647;
   localparam int ITEM_TARGET = 180;
   localparam int TAIL_CYCLES = 200;

   typedef struct {
      logic [ELEM_W-1:0]   value;
      status_type          status;
      logic                last;
   } rsp_item_type;

   class set_merge_checker;
      logic signed [ELEM_W-1:0] set_a [DEPTH];
      logic signed [ELEM_W-1:0] set_b [DEPTH];
      int unsigned cnt_a;
      int unsigned cnt_b;
      rsp_item_type predicted_rsp [$];
      int unsigned failures;

      function void push(logic [ELEM_W-1:0] value, status_type status, logic last);
         rsp_item_type item;
         item.value = value;
         item.status = status;
         item.last = last;
         predicted_rsp.push_back(item);
      endfunction

      function void load_set(bit to_b, logic signed [ELEM_W-1:0] elem);
         int unsigned n;
         logic signed [ELEM_W-1:0] top;
         n = to_b ? cnt_b : cnt_a;
         if (n > 0) begin
            if (to_b) top = set_b[n-1];
            else top = set_a[n-1];
         end
         if (n >= DEPTH) begin
            push('0, STAT_FULL, 1'b1);
         end else if (n > 0 && !(top < elem)) begin
            push('0, STAT_ORDER, 1'b1);
         end else begin
            if (to_b) begin
               set_b[n] = elem;
               cnt_b++;
            end else begin
               set_a[n] = elem;
               cnt_a++;
            end
            push('0, STAT_LOADED, 1'b1);
         end
      endfunction

      function void walk_sets(mode_type kind);
         int unsigned i;
         int unsigned j;
         int unsigned emitted;
         logic signed [ELEM_W-1:0] v;
         bit emit;
         bit keep_a;
         bit keep_b;
         bit keep_both;
         keep_a = (kind == MODE_UNION || kind == MODE_DIFF || kind == MODE_SYMDIFF);
         keep_b = (kind == MODE_UNION || kind == MODE_SYMDIFF);
         keep_both = (kind == MODE_UNION || kind == MODE_INTER);
         i = 0;
         j = 0;
         emitted = 0;
         while (i < cnt_a || j < cnt_b) begin
            if (j >= cnt_b || (i < cnt_a && set_a[i] < set_b[j])) begin
               v = set_a[i];
               emit = keep_a;
               i++;
            end else if (i >= cnt_a || set_b[j] < set_a[i]) begin
               v = set_b[j];
               emit = keep_b;
               j++;
            end else begin
               v = set_a[i];
               emit = keep_both;
               i++;
               j++;
            end
            if (emit) begin
               push(v, STAT_ELEM, 1'b0);
               emitted++;
            end
         end
         if (emitted == 0) push('0, STAT_EMPTY, 1'b1);
         else predicted_rsp[predicted_rsp.size()-1].last = 1'b1;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [ELEM_W-1:0] elem);
         case (mode)
            MODE_LOAD_A: load_set(1'b0, elem);
            MODE_LOAD_B: load_set(1'b1, elem);
            MODE_UNION, MODE_INTER, MODE_DIFF, MODE_SYMDIFF: walk_sets(mode_type'(mode));
            MODE_CLEAR: begin
               cnt_a = 0;
               cnt_b = 0;
               push('0, STAT_CLEARED, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [ELEM_W-1:0] value, logic [STATUS_W-1:0] status,
                                   logic last);
         rsp_item_type want;
         if (predicted_rsp.size() == 0) begin
            failures++;
            $display("%0t: expected no response, actual value %0d status %0d last %0d",
                     $time, $signed(value), status, last);
            return;
         end
         want = predicted_rsp.pop_front();
         if (value !== want.value) begin
            failures++;
            $display("%0t: result_value expected %0d actual %0d",
                     $time, $signed(want.value), $signed(value));
         end
         if (status !== want.status) begin
            failures++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
         if (last !== want.last) begin
            failures++;
            $display("%0t: last expected %0d actual %0d", $time, want.last, last);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = MODE_LOAD_A;
   logic [ELEM_W-1:0]   req_element = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ELEM_W-1:0]   rsp_result_value;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   set_merge_checker sb = new();
   int req_quiet = 0;
   int rsp_quiet = 0;
   int sent = 0;

   sorted_set_merge_engine_unit #(.SET_DEPTH(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   task automatic send(input logic [MODE_W-1:0] mode, input logic [ELEM_W-1:0] elem);
      int gap;
      gap = draw_wait(req_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_element = elem;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(mode, elem);
      if (mode != MODE_UNUSED) sent++;
   endtask

   // Builds two ascending sets that share part of their elements, loads them with
   // occasional stray requests mixed in, then runs every merge kind.
   task automatic run_sets(input bit full_sets);
      longint v;
      int step_max;
      int na;
      int nb;
      int pick;
      int start;
      bit wide;
      logic [MODE_W-1:0] stray;
      logic [ELEM_W-1:0] qa [$];
      logic [ELEM_W-1:0] qb [$];
      wide = 1'($urandom_range(0, 1));
      na = full_sets ? DEPTH : $urandom_range(0, 8);
      nb = full_sets ? DEPTH : $urandom_range(0, 8);
      v = wide ? ELEM_MIN_L + longint'($urandom_range(0, 1 << 30))
               : longint'($urandom_range(0, 20)) - 30;
      step_max = wide ? (1 << 26) : 3;
      while ((qa.size() < na || qb.size() < nb) && v <= ELEM_MAX_L) begin
         pick = $urandom_range(0, 2);
         if (qa.size() >= na) pick = 1;
         else if (qb.size() >= nb) pick = 0;
         if (pick != 1) qa.push_back(v[ELEM_W-1:0]);
         if (pick != 0) qb.push_back(v[ELEM_W-1:0]);
         v += longint'($urandom_range(1, step_max));
      end
      send(MODE_CLEAR, $urandom());
      while (qa.size() + qb.size() > 0) begin
         if ($urandom_range(0, 11) == 0) begin
            stray = MODE_W'($urandom_range(0, 7));
            if (stray == MODE_CLEAR) stray = MODE_UNUSED;
            send(stray, $urandom());
         end
         if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1) == 1))
            send(MODE_LOAD_A, qa.pop_front());
         else
            send(MODE_LOAD_B, qb.pop_front());
      end
      if (full_sets) begin
         send(MODE_LOAD_A, $urandom());
         send(MODE_LOAD_B, $urandom());
      end
      start = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) send(MODE_W'(MODE_UNION + ((start + k) % 4)), $urandom());
   endtask

   initial begin
      while (reset) @(posedge clock);
      forever begin
         int stall;
         stall = draw_wait(rsp_quiet);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_response(rsp_result_value, rsp_status, rsp_last);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(MODE_UNION, '0);
      send(MODE_INTER, '1);
      send(MODE_DIFF, '0);
      send(MODE_SYMDIFF, '1);
      send(MODE_LOAD_A, ELEM_MIN);
      send(MODE_LOAD_A, ELEM_MIN);
      send(MODE_LOAD_A, -5);
      send(MODE_LOAD_A, -9);
      send(MODE_LOAD_A, 100);
      send(MODE_LOAD_B, -5);
      send(MODE_LOAD_B, ELEM_MAX);
      send(MODE_LOAD_B, 100);
      send(MODE_LOAD_A, ELEM_MAX);
      send(MODE_LOAD_A, ELEM_MAX);
      send(MODE_UNION, '0);
      send(MODE_INTER, '0);
      send(MODE_DIFF, '0);
      send(MODE_SYMDIFF, '0);
      send(MODE_UNUSED, '1);
      send(MODE_CLEAR, '1);
      send(MODE_SYMDIFF, '0);
      send(MODE_LOAD_B, '0);
      send(MODE_DIFF, '0);
      send(MODE_INTER, '0);

      run_sets(1'b1);
      while (sent < ITEM_TARGET) run_sets($urandom_range(0, 5) == 0);

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.predicted_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
